// ===== design/atml_pkg.sv =====
// Shared types and constants for the AT modem link sequencer.
// Holds the beat payload structs, the event codes and the register defaults.
// No dependencies.
package atml_pkg;

  localparam int MAX_SCAN_ROWS_DEF = 16;
  localparam int EVQ_DEPTH_DEF     = 2;
  localparam int OUTQ_DEPTH_DEF    = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_BACKOFF  = 2'd3;

  localparam logic [CFG_DATA_W-1:0] CMD_TIMEOUT_RST   = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] SCAN_TIMEOUT_RST  = 16'd8000;
  localparam logic [CFG_DATA_W-1:0] POLL_INTERVAL_RST = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] FAIL_BACKOFF_RST  = 16'd5000;

  // Input kind codes as they arrive on the port
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_LINE   = 3'd1;
  localparam logic [2:0] KIND_CRED   = 3'd2;
  localparam logic [2:0] KIND_SCAN   = 3'd3;
  localparam logic [2:0] KIND_ATTACH = 3'd4;

  // Command codes
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_ECHO_OFF = 3'd1;
  localparam logic [2:0] CMD_STATION  = 3'd2;
  localparam logic [2:0] CMD_JOIN     = 3'd3;
  localparam logic [2:0] CMD_QUIT     = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;
  localparam logic [2:0] CMD_LIST     = 3'd6;

  // Link status codes
  localparam logic [1:0] ST_OFF        = 2'd0;
  localparam logic [1:0] ST_CONNECTING = 2'd1;
  localparam logic [1:0] ST_CONNECTED  = 2'd2;
  localparam logic [1:0] ST_FAILED     = 2'd3;

  typedef enum logic [2:0] {
    EV_TICK,
    EV_LINE,
    EV_CRED,
    EV_SCAN,
    EV_ATTACH,
    EV_NONE
  } ev_kind_t;

  typedef enum logic [3:0] {
    LN_OTHER,
    LN_CONNECTED,
    LN_GOT_IP,
    LN_DISCONNECT,
    LN_JOIN_REPLY,
    LN_IP_REPLY,
    LN_OK,
    LN_ERROR,
    LN_SCAN_ROW
  } line_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [31:0]       now_ms;
    logic [3:0]        line_kind;
    logic              parse_ok;
    logic signed [7:0] line_rssi;
    logic [31:0]       line_ip;
    logic              ssid_present;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [1:0]        link_status;
    logic signed [7:0] rssi;
    logic [31:0]       ip_address;
    logic [4:0]        scan_rows;
    logic              scan_active;
    logic              scan_finished;
    logic              scan_accepted;
  } out_item_t;

  // Classified event handed from the front to the back
  typedef struct packed {
    ev_kind_t          kind;
    line_t             line;
    logic [31:0]       now_ms;
    logic              parse_ok;
    logic signed [7:0] rssi;
    logic [31:0]       ip;
    logic              ssid;
  } event_t;

endpackage

// ===== design/atml_queue.sv =====
// Small register queue used between the front and the back and on the result side.
// Generic width and depth; no package dependency.
module atml_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/atml_front.sv =====
// Front end: classifies each accepted input beat into an event for the back end.
// Depends on atml_pkg.
module atml_front
  import atml_pkg::*;
(
  input  in_item_t item,
  output event_t   ev
);

  always_comb begin
    ev.now_ms   = item.now_ms;
    ev.parse_ok = item.parse_ok;
    ev.rssi     = item.line_rssi;
    ev.ip       = item.line_ip;
    ev.ssid     = item.ssid_present;

    case (item.kind)
      KIND_TICK:   ev.kind = EV_TICK;
      KIND_LINE:   ev.kind = EV_LINE;
      KIND_CRED:   ev.kind = EV_CRED;
      KIND_SCAN:   ev.kind = EV_SCAN;
      KIND_ATTACH: ev.kind = EV_ATTACH;
      default:     ev.kind = EV_NONE;
    endcase

    // Unknown reply classes fold into "other"
    if (item.line_kind inside {[4'd0:4'd8]}) begin
      ev.line = line_t'(item.line_kind);
    end else begin
      ev.line = LN_OTHER;
    end
  end

endmodule

// ===== design/atml_back.sv =====
// Back end: link state machine, timers, scan bookkeeping and configuration registers.
// Takes one event per cycle while the result queue has room and builds its result beat. Depends on atml_pkg.
module atml_back
  import atml_pkg::*;
#(
  parameter int MAX_SCAN_ROWS = MAX_SCAN_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  ev_valid,
  input  event_t                ev,
  output logic                  ev_take,
  input  logic                  res_full,
  output logic                  res_push,
  output out_item_t             res
);

  localparam int ROW_W = $clog2(MAX_SCAN_ROWS + 1);

  typedef enum logic [2:0] {
    LS_INIT,
    LS_IDLE,
    LS_JOINING,
    LS_CONNECTED,
    LS_FAILED
  } link_t;

  link_t             ls_r, ls_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              pend_r, pend_nxt;
  logic [31:0]       sent_t_r, sent_t_nxt;
  logic [31:0]       fail_t_r, fail_t_nxt;
  logic [31:0]       poll_t_r, poll_t_nxt;
  logic [31:0]       scan_t_r, scan_t_nxt;
  logic              scan_r, scan_nxt;
  logic              rejoin_r, rejoin_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              ssid_r, ssid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic signed [7:0] rssi_r, rssi_nxt;
  logic [31:0]       ip_r, ip_nxt;

  logic [CFG_DATA_W-1:0] cmd_to_r, scan_to_r, poll_iv_r, backoff_r;

  logic [2:0] cmd;
  logic       finished, accepted;
  logic       cmd_exp, scan_exp, fail_exp, poll_exp;

  assign ev_take  = ev_valid && !res_full;
  assign res_push = ev_take;

  always_comb begin
    ls_nxt     = ls_r;
    step_nxt   = step_r;
    pend_nxt   = pend_r;
    sent_t_nxt = sent_t_r;
    fail_t_nxt = fail_t_r;
    poll_t_nxt = poll_t_r;
    scan_t_nxt = scan_t_r;
    scan_nxt   = scan_r;
    rejoin_nxt = rejoin_r;
    row_nxt    = row_r;
    ssid_nxt   = ssid_r;
    status_nxt = status_r;
    rssi_nxt   = rssi_r;
    ip_nxt     = ip_r;
    cmd        = CMD_NONE;
    finished   = 1'b0;
    accepted   = 1'b0;

    // Ages are modulo 2^32 and must strictly exceed the register
    cmd_exp  = pend_r && ((ev.now_ms - sent_t_r) > 32'(cmd_to_r));
    scan_exp = scan_r && ((ev.now_ms - scan_t_r) > 32'(scan_to_r));
    fail_exp = (ev.now_ms - fail_t_r) > 32'(backoff_r);
    poll_exp = (ev.now_ms - poll_t_r) > 32'(poll_iv_r);

    case (ev.kind)
      EV_TICK: begin
        if (cmd_exp) begin
          pend_nxt = 1'b0;
          if (ls_r == LS_JOINING) begin
            ls_nxt     = LS_FAILED;
            status_nxt = ST_FAILED;
            fail_t_nxt = ev.now_ms;
            fail_exp   = 1'b0;
          end else if (ls_r == LS_INIT) begin
            if (step_r != 2'd3) step_nxt = step_r + 2'd1;
          end
        end
        if (scan_exp) begin
          scan_nxt = 1'b0;
          finished = 1'b1;
          pend_nxt = 1'b0;
          if (rejoin_r) begin
            rejoin_nxt = 1'b0;
            cmd        = CMD_JOIN;
            pend_nxt   = 1'b1;
            sent_t_nxt = ev.now_ms;
            ls_nxt     = LS_JOINING;
            status_nxt = ST_CONNECTING;
          end
        end
        case (ls_nxt)
          LS_INIT: begin
            if (!pend_nxt) begin
              if (step_nxt < 2'd2) begin
                cmd        = (step_nxt == 2'd0) ? CMD_ECHO_OFF : CMD_STATION;
                pend_nxt   = 1'b1;
                sent_t_nxt = ev.now_ms;
              end else begin
                ls_nxt = LS_IDLE;
                if (ssid_r) begin
                  cmd        = CMD_JOIN;
                  pend_nxt   = 1'b1;
                  sent_t_nxt = ev.now_ms;
                  ls_nxt     = LS_JOINING;
                  status_nxt = ST_CONNECTING;
                end
              end
            end
          end
          LS_FAILED: begin
            if (fail_exp && ssid_r) begin
              cmd        = CMD_JOIN;
              pend_nxt   = 1'b1;
              sent_t_nxt = ev.now_ms;
              ls_nxt     = LS_JOINING;
              status_nxt = ST_CONNECTING;
            end
          end
          LS_CONNECTED: begin
            if (!scan_nxt && !pend_nxt && poll_exp) begin
              poll_t_nxt = ev.now_ms;
              cmd        = CMD_QUERY;
              pend_nxt   = 1'b1;
              sent_t_nxt = ev.now_ms;
            end
          end
          default: ;
        endcase
      end

      EV_LINE: begin
        if (scan_r && ev.line == LN_SCAN_ROW) begin
          if ((32'(row_r) < 32'(MAX_SCAN_ROWS)) && ev.parse_ok) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else if (scan_r && (ev.line == LN_OK || ev.line == LN_ERROR)) begin
          // Any final reply closes the scan, clears the pending command and issues a held rejoin
          scan_nxt = 1'b0;
          finished = 1'b1;
          pend_nxt = 1'b0;
          if (rejoin_r) begin
            rejoin_nxt = 1'b0;
            cmd        = CMD_JOIN;
            pend_nxt   = 1'b1;
            sent_t_nxt = ev.now_ms;
            ls_nxt     = LS_JOINING;
            status_nxt = ST_CONNECTING;
          end
        end else begin
          case (ev.line)
            LN_GOT_IP: begin
              ls_nxt     = LS_CONNECTED;
              status_nxt = ST_CONNECTED;
              pend_nxt   = 1'b0;
            end
            LN_DISCONNECT: begin
              if (ls_r == LS_CONNECTED) begin
                ls_nxt     = LS_IDLE;
                status_nxt = ST_OFF;
                rssi_nxt   = '0;
                ip_nxt     = '0;
                if (ssid_r) begin
                  if (scan_r) begin
                    rejoin_nxt = 1'b1;
                  end else begin
                    cmd        = CMD_JOIN;
                    pend_nxt   = 1'b1;
                    sent_t_nxt = ev.now_ms;
                    ls_nxt     = LS_JOINING;
                    status_nxt = ST_CONNECTING;
                  end
                end
              end
            end
            LN_JOIN_REPLY: begin
              if (ev.parse_ok) rssi_nxt = ev.rssi;
            end
            LN_IP_REPLY: begin
              if (ev.parse_ok) ip_nxt = ev.ip;
            end
            LN_ERROR: begin
              if (ls_r == LS_JOINING) begin
                ls_nxt     = LS_FAILED;
                status_nxt = ST_FAILED;
                fail_t_nxt = ev.now_ms;
              end
              pend_nxt = 1'b0;
            end
            LN_OK: begin
              if (ls_r == LS_INIT) begin
                if (step_r != 2'd3) step_nxt = step_r + 2'd1;
                pend_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      EV_CRED: begin
        ssid_nxt   = ev.ssid;
        cmd        = ev.ssid ? CMD_JOIN : CMD_QUIT;
        pend_nxt   = 1'b1;
        sent_t_nxt = ev.now_ms;
        if (ev.ssid) begin
          ls_nxt     = LS_JOINING;
          status_nxt = ST_CONNECTING;
        end else begin
          ls_nxt     = LS_IDLE;
          status_nxt = ST_OFF;
        end
      end

      EV_SCAN: begin
        if (!scan_r) begin
          scan_nxt   = 1'b1;
          row_nxt    = '0;
          scan_t_nxt = ev.now_ms;
          cmd        = CMD_LIST;
          pend_nxt   = 1'b1;
          sent_t_nxt = ev.now_ms;
          accepted   = 1'b1;
        end
      end

      EV_ATTACH: ssid_nxt = ev.ssid;

      default: ;
    endcase

    res.command       = cmd;
    res.link_status   = status_nxt;
    res.rssi          = rssi_nxt;
    res.ip_address    = ip_nxt;
    res.scan_rows     = (32'(row_nxt) > 32'd31) ? 5'd31 : 5'(row_nxt);
    res.scan_active   = scan_nxt;
    res.scan_finished = finished;
    res.scan_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r     <= LS_INIT;
      step_r   <= '0;
      pend_r   <= 1'b0;
      sent_t_r <= '0;
      fail_t_r <= '0;
      poll_t_r <= '0;
      scan_t_r <= '0;
      scan_r   <= 1'b0;
      rejoin_r <= 1'b0;
      row_r    <= '0;
      ssid_r   <= 1'b0;
      status_r <= ST_OFF;
      rssi_r   <= '0;
      ip_r     <= '0;
    end else if (ev_take) begin
      ls_r     <= ls_nxt;
      step_r   <= step_nxt;
      pend_r   <= pend_nxt;
      sent_t_r <= sent_t_nxt;
      fail_t_r <= fail_t_nxt;
      poll_t_r <= poll_t_nxt;
      scan_t_r <= scan_t_nxt;
      scan_r   <= scan_nxt;
      rejoin_r <= rejoin_nxt;
      row_r    <= row_nxt;
      ssid_r   <= ssid_nxt;
      status_r <= status_nxt;
      rssi_r   <= rssi_nxt;
      ip_r     <= ip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_to_r  <= CMD_TIMEOUT_RST;
      scan_to_r <= SCAN_TIMEOUT_RST;
      poll_iv_r <= POLL_INTERVAL_RST;
      backoff_r <= FAIL_BACKOFF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CMD_TIMEOUT:   cmd_to_r  <= cfg_wdata;
        CFG_SCAN_TIMEOUT:  scan_to_r <= cfg_wdata;
        CFG_POLL_INTERVAL: poll_iv_r <= cfg_wdata;
        CFG_FAIL_BACKOFF:  backoff_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/at_modem_link_sequencer.sv =====
// Top level of the AT modem link sequencer: front classifier, event queue,
// back end state machine and result queue. Depends on atml_pkg and the atml_* modules.
//
// Takes one event beat per clock while the event queue has room and returns exactly
// one result beat for each, in order. A beat is held in the event queue, executed
// by the back end and held in the result queue until it is popped. The sustained
// rate is one beat per cycle while neither side stalls, set by the back end executor.
// The event queue and the result queue let either side stall without stopping the
// other. Configuration writes take effect at once and are meant for idle time.
module at_modem_link_sequencer
  import atml_pkg::*;
#(
  parameter int MAX_SCAN_ROWS = MAX_SCAN_ROWS_DEF,
  parameter int EVQ_DEPTH     = EVQ_DEPTH_DEF,
  parameter int OUTQ_DEPTH    = OUTQ_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  event_t    ev_in, ev_head;
  logic      ev_empty, ev_take;
  logic      res_full, res_push;
  out_item_t res;

  atml_front u_front (
    .item (in_data),
    .ev   (ev_in)
  );

  atml_queue #(
    .WIDTH ($bits(event_t)),
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (ev_in),
    .full    (in_full),
    .pop     (ev_take),
    .empty   (ev_empty),
    .rd_data (ev_head)
  );

  atml_back #(
    .MAX_SCAN_ROWS (MAX_SCAN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ev_valid  (!ev_empty),
    .ev        (ev_head),
    .ev_take   (ev_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  atml_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (out_data)
  );

  // Nothing waits on the result side straight after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A scan cannot both close and still be running on one beat
  a_finish_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_data.scan_finished && out_data.scan_active))
    else $error("scan finished and active on the same beat");

  // The list command only goes out with a freshly started, empty scan
  a_list_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.command == CMD_LIST) |->
      (out_data.scan_accepted && out_data.scan_active && out_data.scan_rows == 5'd0))
    else $error("list command without a started scan");

  // The back end only fires on a queued event with room for its result
  a_back_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ev_take |-> (!ev_empty && !res_full && res_push))
    else $error("back end fired without event or result space");

endmodule
